[sv/m3i_pkg.sv]
`timescale 1ns / 1ps

package m3i_pkg;

    // determinant of 32-bit entries: three 32 x 64 products summed
    localparam int DET_W     = 98;
    localparam int ADJ_W     = 64;
    localparam int N_ENT     = 9;
    localparam int DIV_STEPS = 32;
    localparam int DIV_STAGES = DIV_STEPS + 1;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // cofactor k = m[a] * m[b] - m[c] * m[d], already transposed
    localparam logic [3:0] COF_IDX [N_ENT][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [31:0] in_r0c0;
        logic signed [31:0] in_r0c1;
        logic signed [31:0] in_r0c2;
        logic signed [31:0] in_r1c0;
        logic signed [31:0] in_r1c1;
        logic signed [31:0] in_r1c2;
        logic signed [31:0] in_r2c0;
        logic signed [31:0] in_r2c1;
        logic signed [31:0] in_r2c2;
    } mat_word_t;

    typedef struct packed {
        logic signed [31:0] inv_r0c0;
        logic signed [31:0] inv_r0c1;
        logic signed [31:0] inv_r0c2;
        logic signed [31:0] inv_r1c0;
        logic signed [31:0] inv_r1c1;
        logic signed [31:0] inv_r1c2;
        logic signed [31:0] inv_r2c0;
        logic signed [31:0] inv_r2c1;
        logic signed [31:0] inv_r2c2;
        logic signed [31:0] determinant;
        logic               singular;
    } res_word_t;

    // per-word flags that ride alongside the divider
    typedef struct packed {
        logic             zero;
        logic [N_ENT-1:0] neg;
        logic [31:0]      det;
    } side_t;

    // apply sign to a rounded magnitude and clamp to 32 bits
    function automatic logic [31:0] sat32(input logic neg, input logic big,
                                          input logic [31:0] mag);
        logic [31:0] r;
        if (big) begin
            r = neg ? SAT_MIN : SAT_MAX;
        end else if (!neg) begin
            r = mag[31] ? SAT_MAX : mag;
        end else begin
            r = (mag > SAT_MIN) ? SAT_MIN : (32'd0 - mag);
        end
        return r;
    endfunction

endpackage

[sv/m3i_div.sv]
`timescale 1ns / 1ps

module m3i_div #(
    parameter int XW = 100
) (
    input  logic                       clk,
    input  logic [m3i_pkg::DIV_STAGES-1:0] adv,
    input  logic [XW-1:0]              x [m3i_pkg::N_ENT],
    input  logic [m3i_pkg::DET_W:0]    d2,
    output logic [31:0]                q [m3i_pkg::N_ENT],
    output logic [m3i_pkg::N_ENT-1:0]  ovf
);

    localparam int NE = m3i_pkg::N_ENT;
    localparam int NSTG = m3i_pkg::DIV_STAGES;
    localparam int STEPS = m3i_pkg::DIV_STEPS;
    localparam int CW = m3i_pkg::DET_W + 1 + STEPS;

    logic [XW-1:0]              r_reg   [NSTG][NE];
    logic [31:0]                q_reg   [NSTG][NE];
    logic [NE-1:0]              ovf_reg [NSTG];
    logic [m3i_pkg::DET_W:0]    d2_reg  [NSTG];

    logic [NE-1:0] ovf_next;

    // first stage: quotient of 2^32 or more saturates
    always_comb
    begin
        for (int j = 0; j < NE; j++)
        begin
            ovf_next[j] = CW'(x[j]) >= (CW'(d2) << STEPS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int j = 0; j < NE; j++)
            begin
                r_reg[0][j] <= x[j];
                q_reg[0][j] <= '0;
            end
            ovf_reg[0] <= ovf_next;
            d2_reg[0]  <= d2;
        end
    end

    // one restoring step per stage, quotient bit STEPS - s
    for (genvar s = 1; s < NSTG; s++)
    begin : g_step
        localparam int SH = STEPS - s;
        logic [XW-1:0] r_next [NE];
        logic [31:0]   q_next [NE];
        logic [CW-1:0] dsh;

        always_comb
        begin
            dsh = CW'(d2_reg[s-1]) << SH;
            for (int j = 0; j < NE; j++)
            begin
                if (CW'(r_reg[s-1][j]) >= dsh)
                begin
                    r_next[j] = r_reg[s-1][j] - XW'(dsh);
                    q_next[j] = {q_reg[s-1][j][30:0], 1'b1};
                end
                else
                begin
                    r_next[j] = r_reg[s-1][j];
                    q_next[j] = {q_reg[s-1][j][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                r_reg[s]   <= r_next;
                q_reg[s]   <= q_next;
                ovf_reg[s] <= ovf_reg[s-1];
                d2_reg[s]  <= d2_reg[s-1];
            end
        end
    end

    assign q   = q_reg[NSTG-1];
    assign ovf = ovf_reg[NSTG-1];

endmodule

[sv/matrix3_inverse_top.sv]
`timescale 1ns / 1ps

// 3x3 matrix inverse by adjugate over determinant, signed fixed point with
// FRAC_BITS fraction bits. one matrix word enters per cycle, unless every
// stage is full and the result side stalls; its result word leaves after
// 7 stages of cofactor multiplies, determinant sum and setup, 33 stages of
// a restoring divider (an overflow check, then one quotient bit per stage,
// nine lanes sharing the divisor), and one output stage; the divider is
// fully pipelined. a stall at the result side only stops stages that hold a
// valid word, so bubbles close up and a new matrix is still taken while a
// finished result waits. every output is rounded to nearest, ties away from
// zero, and clamped to 32 bits; a zero determinant raises singular and
// zeroes every other field. no memories, no clearing pass after reset.
module matrix3_inverse_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    output logic               mat_stall,
    input  m3i_pkg::mat_word_t mat,
    output logic               res_valid,
    input  logic               res_stall,
    output m3i_pkg::res_word_t res
);

    localparam int NE = m3i_pkg::N_ENT;
    localparam int DW = m3i_pkg::DET_W;
    localparam int AW = m3i_pkg::ADJ_W;
    // dividend: |adj| scaled by 2^(2F+1) plus |det|
    localparam int NUM_W = AW + 2 * FRAC_BITS + 1;
    localparam int XW = ((NUM_W > DW) ? NUM_W : DW) + 1;
    localparam int N_FRONT = 7;
    localparam int N_DIV = m3i_pkg::DIV_STAGES;
    localparam int NS = N_FRONT + N_DIV + 1;

    // stage valid bits and advance enables
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] adv;

    // a stage moves when any stage at or after it is empty, or the result is taken
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            adv[k] = (((~v_reg) & ({NS{1'b1}} << k)) != '0) || !res_stall;
        end
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                v_next[k] = adv[k] ? mat_valid : v_reg[k];
            end
            else
            begin
                v_next[k] = adv[k] ? v_reg[k-1] : v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign mat_stall = !adv[0];
    assign res_valid = v_reg[NS-1];

    // unpack the input word, row-major
    logic signed [31:0] m [NE];

    always_comb
    begin
        m[0] = mat.in_r0c0;
        m[1] = mat.in_r0c1;
        m[2] = mat.in_r0c2;
        m[3] = mat.in_r1c0;
        m[4] = mat.in_r1c1;
        m[5] = mat.in_r1c2;
        m[6] = mat.in_r2c0;
        m[7] = mat.in_r2c1;
        m[8] = mat.in_r2c2;
    end

    // stage 0: the eighteen 2x2 products
    logic signed [63:0] pa0_reg [NE];
    logic signed [63:0] pb0_reg [NE];
    logic signed [31:0] mt0_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < NE; k++)
            begin
                pa0_reg[k] <= m[m3i_pkg::COF_IDX[k][0]] * m[m3i_pkg::COF_IDX[k][1]];
                pb0_reg[k] <= m[m3i_pkg::COF_IDX[k][2]] * m[m3i_pkg::COF_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++)
            begin
                mt0_reg[j] <= m[j];
            end
        end
    end

    // stage 1: adjugate entries, exact in 64 bits
    logic signed [63:0] adj1_reg [NE];
    logic signed [31:0] mt1_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < NE; k++)
            begin
                adj1_reg[k] <= pa0_reg[k] - pb0_reg[k];
            end
            mt1_reg <= mt0_reg;
        end
    end

    // stage 2: first-row expansion, each 32 x 64 product split into two halves
    logic signed [64:0] pl2_reg [3];
    logic signed [63:0] ph2_reg [3];
    logic signed [63:0] adj2_reg [NE];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                pl2_reg[j] <= mt1_reg[j] * $signed({1'b0, adj1_reg[3*j][31:0]});
                ph2_reg[j] <= mt1_reg[j] * $signed(adj1_reg[3*j][63:32]);
            end
            adj2_reg <= adj1_reg;
        end
    end

    // stage 3: recombine the halves
    logic signed [DW-1:0] term3_reg [3];
    logic signed [63:0]   adj3_reg [NE];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                term3_reg[j] <= (DW'(ph2_reg[j]) <<< 32) + DW'(pl2_reg[j]);
            end
            adj3_reg <= adj2_reg;
        end
    end

    // stage 4: determinant with 3F fraction bits
    logic signed [DW-1:0] det4_reg;
    logic signed [63:0]   adj4_reg [NE];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            det4_reg <= term3_reg[0] + term3_reg[1] + term3_reg[2];
            adj4_reg <= adj3_reg;
        end
    end

    // stage 5: split into sign and magnitude
    logic          dneg5_reg;
    logic          zero5_reg;
    logic [DW-1:0] dmag5_reg;
    logic [NE-1:0] aneg5_reg;
    logic [AW-1:0] amag5_reg [NE];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            dneg5_reg <= det4_reg[DW-1];
            zero5_reg <= (det4_reg == '0);
            dmag5_reg <= det4_reg[DW-1] ? DW'(-det4_reg) : DW'(det4_reg);
            for (int k = 0; k < NE; k++)
            begin
                aneg5_reg[k] <= adj4_reg[k][AW-1];
                amag5_reg[k] <= adj4_reg[k][AW-1] ? AW'(-adj4_reg[k]) : AW'(adj4_reg[k]);
            end
        end
    end

    // stage 6: divider operands, rounding bias folded in, and the rounded determinant
    logic [XW-1:0]     x6_reg [NE];
    logic [DW:0]       d2_6_reg;
    m3i_pkg::side_t    side6_reg;
    logic [DW:0]       dround;
    logic [DW:0]       dq;

    always_comb
    begin
        dround = (DW+1)'(dmag5_reg) + ((DW+1)'(1) << (2 * FRAC_BITS - 1));
        dq     = dround >> (2 * FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int k = 0; k < NE; k++)
            begin
                x6_reg[k] <= (XW'(amag5_reg[k]) << (2 * FRAC_BITS + 1)) + XW'(dmag5_reg);
            end
            d2_6_reg       <= {dmag5_reg, 1'b0};
            side6_reg.zero <= zero5_reg;
            side6_reg.neg  <= aneg5_reg ^ {NE{dneg5_reg}};
            side6_reg.det  <= m3i_pkg::sat32(dneg5_reg, |dq[DW:32], dq[31:0]);
        end
    end

    // stages 7 to 39: rounded quotients of the nine entries
    logic [31:0]   q_div [NE];
    logic [NE-1:0] ovf_div;

    m3i_div #(
        .XW (XW)
    ) u_div (
        .clk (clk),
        .adv (adv[N_FRONT +: N_DIV]),
        .x   (x6_reg),
        .d2  (d2_6_reg),
        .q   (q_div),
        .ovf (ovf_div)
    );

    // flags and determinant travel beside the divider
    m3i_pkg::side_t side_reg [N_DIV];

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < N_DIV; s++)
        begin
            if (adv[N_FRONT + s])
            begin
                side_reg[s] <= (s == 0) ? side6_reg : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // last stage: sign, clamp, singular masking
    m3i_pkg::res_word_t res_next;
    m3i_pkg::res_word_t res_reg;
    logic [31:0]        inv [NE];
    m3i_pkg::side_t     sd;

    always_comb
    begin
        sd = side_reg[N_DIV-1];
        for (int k = 0; k < NE; k++)
        begin
            inv[k] = sd.zero ? 32'd0 : m3i_pkg::sat32(sd.neg[k], ovf_div[k], q_div[k]);
        end
        res_next.inv_r0c0    = inv[0];
        res_next.inv_r0c1    = inv[1];
        res_next.inv_r0c2    = inv[2];
        res_next.inv_r1c0    = inv[3];
        res_next.inv_r1c1    = inv[4];
        res_next.inv_r1c2    = inv[5];
        res_next.inv_r2c0    = inv[6];
        res_next.inv_r2c1    = inv[7];
        res_next.inv_r2c2    = inv[8];
        res_next.determinant = sd.zero ? 32'd0 : sd.det;
        res_next.singular    = sd.zero;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    // a singular result carries a zero determinant and a zero diagonal
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.singular |-> res.determinant == 0 && res.inv_r0c0 == 0
            && res.inv_r1c1 == 0 && res.inv_r2c2 == 0)
        else $error("singular result with nonzero fields");

    // input is held back only when every stage is full and the output waits
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> res_valid && res_stall && (&v_reg))
        else $error("input stalled with room in the pipeline");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_stall |=> v_reg[0])
        else $error("accepted word lost at pipeline entry");
`endif

endmodule

[sim/matrix3_inverse_checker.sv]
`timescale 1ns / 1ps

module matrix3_inverse_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    input  logic               mat_stall,
    input  m3i_pkg::mat_word_t mat,
    input  logic               res_valid,
    input  logic               res_stall,
    input  m3i_pkg::res_word_t res,
    output int                 fail_count,
    output int                 pending,
    output int                 n_results,
    output int                 n_singular
);

    m3i_pkg::res_word_t inverse_q[$];

    // exact value num/den rounded half away from zero, clamped to 32 bits
    function automatic logic [31:0] round_clamp(input logic signed [255:0] num,
                                                input logic signed [255:0] den);
        logic signed [255:0] n, d, q;
        logic neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (2 * n + d) / (2 * d);
        if (neg) q = -q;
        if (q > 256'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (q < -256'sh8000_0000) return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic m3i_pkg::res_word_t invert_matrix(input m3i_pkg::mat_word_t w);
        logic signed [255:0] m [9];
        logic signed [255:0] adj [9];
        logic signed [255:0] det, one;
        logic [31:0] e [9];
        m3i_pkg::res_word_t r;
        e = '{w.in_r0c0, w.in_r0c1, w.in_r0c2, w.in_r1c0, w.in_r1c1, w.in_r1c2,
              w.in_r2c0, w.in_r2c1, w.in_r2c2};
        for (int k = 0; k < 9; k++) m[k] = $signed(e[k]);
        // transposed cofactors
        adj[0] = m[4] * m[8] - m[5] * m[7];
        adj[1] = m[2] * m[7] - m[1] * m[8];
        adj[2] = m[1] * m[5] - m[2] * m[4];
        adj[3] = m[5] * m[6] - m[3] * m[8];
        adj[4] = m[0] * m[8] - m[2] * m[6];
        adj[5] = m[2] * m[3] - m[0] * m[5];
        adj[6] = m[3] * m[7] - m[4] * m[6];
        adj[7] = m[1] * m[6] - m[0] * m[7];
        adj[8] = m[0] * m[4] - m[1] * m[3];
        det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        one = 256'sd1 <<< (2 * FRAC_BITS);
        for (int k = 0; k < 9; k++) e[k] = round_clamp(adj[k] <<< (2 * FRAC_BITS), det);
        r.inv_r0c0 = e[0]; r.inv_r0c1 = e[1]; r.inv_r0c2 = e[2];
        r.inv_r1c0 = e[3]; r.inv_r1c1 = e[4]; r.inv_r1c2 = e[5];
        r.inv_r2c0 = e[6]; r.inv_r2c1 = e[7]; r.inv_r2c2 = e[8];
        r.determinant = round_clamp(det, one);
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        n_results = 0;
        n_singular = 0;
    end

    assign pending = inverse_q.size();

    always @(posedge clk) begin
        m3i_pkg::res_word_t want;
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                if (inverse_q.size() == 0) begin
                    report("unexpected word", res[31:0], 32'd0);
                end else begin
                    want = inverse_q.pop_front();
                    n_results++;
                    if (want.singular) n_singular++;
                    if (res.inv_r0c0 !== want.inv_r0c0) report("r0c0", res.inv_r0c0, want.inv_r0c0);
                    if (res.inv_r0c1 !== want.inv_r0c1) report("r0c1", res.inv_r0c1, want.inv_r0c1);
                    if (res.inv_r0c2 !== want.inv_r0c2) report("r0c2", res.inv_r0c2, want.inv_r0c2);
                    if (res.inv_r1c0 !== want.inv_r1c0) report("r1c0", res.inv_r1c0, want.inv_r1c0);
                    if (res.inv_r1c1 !== want.inv_r1c1) report("r1c1", res.inv_r1c1, want.inv_r1c1);
                    if (res.inv_r1c2 !== want.inv_r1c2) report("r1c2", res.inv_r1c2, want.inv_r1c2);
                    if (res.inv_r2c0 !== want.inv_r2c0) report("r2c0", res.inv_r2c0, want.inv_r2c0);
                    if (res.inv_r2c1 !== want.inv_r2c1) report("r2c1", res.inv_r2c1, want.inv_r2c1);
                    if (res.inv_r2c2 !== want.inv_r2c2) report("r2c2", res.inv_r2c2, want.inv_r2c2);
                    if (res.determinant !== want.determinant)
                        report("determinant", res.determinant, want.determinant);
                    if (res.singular !== want.singular)
                        report("singular", 32'(res.singular), 32'(want.singular));
                end
            end
            if (mat_valid && !mat_stall) inverse_q.push_back(invert_matrix(mat));
        end
    end

endmodule

[sim/matrix3_inverse_top_tb.sv]
`timescale 1ns / 1ps

module matrix3_inverse_top_tb;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 41;
    localparam int N_RANDOM  = 1930;
    // the limit covers the worst case per word, with the longest gaps and stalls,
    // by a wide margin
    localparam int CYCLE_LIMIT = (N_RANDOM + 100) * 100 + 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               mat_valid = 1'b0;
    logic               mat_stall;
    m3i_pkg::mat_word_t mat = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    m3i_pkg::res_word_t res;

    int fail_count, pending, n_results, n_singular;
    int cycle_count = 0;
    bit calm = 1'b0;        // no idling in the closing stretch
    int n_sent = 0;

    always #2 clk = ~clk;

    matrix3_inverse_top #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    matrix3_inverse_checker #(.FRAC_BITS(FRAC_BITS)) chk (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .fail_count(fail_count), .pending(pending),
        .n_results(n_results), .n_singular(n_singular)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stalls in bursts of random length
    initial begin
        int n;
        @(posedge clk iff rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
                res_stall <= 1'b0;
            end
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clk);
        end
    end

    // one random 32-bit entry, weighted toward small and edge values
    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
            3, 4: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            5: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom();
        endcase
    endfunction

    function automatic m3i_pkg::mat_word_t rand_matrix();
        m3i_pkg::mat_word_t w;
        for (int k = 0; k < 9; k++) w[32*k +: 32] = rand_entry();
        // sometimes force singularity by repeating a row or zeroing one
        case ($urandom_range(0, 11))
            0: begin w.in_r2c0 = w.in_r0c0; w.in_r2c1 = w.in_r0c1; w.in_r2c2 = w.in_r0c2; end
            1: begin w.in_r1c0 = '0; w.in_r1c1 = '0; w.in_r1c2 = '0; end
            default: ;
        endcase
        return w;
    endfunction

    function automatic m3i_pkg::mat_word_t diag(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c);
        m3i_pkg::mat_word_t w;
        w = '0;
        w.in_r0c0 = a; w.in_r1c1 = b; w.in_r2c2 = c;
        return w;
    endfunction

    // hold the word until accepted, with optional gap first
    task automatic send_matrix(input m3i_pkg::mat_word_t w);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 9);
            mat_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        mat_valid <= 1'b1;
        mat <= w;
        @(posedge clk);
        while (mat_stall) @(posedge clk);
        n_sent++;
    endtask

    task automatic drain();
        mat_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        m3i_pkg::mat_word_t w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, scaled diagonals, extremes, singular and tiny det
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag(32'h0000_0001, ONE, ONE));
        send_matrix(diag(32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0007));
        send_matrix('0);
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'hFFFF_FFFF}});
        w = diag(ONE, ONE, ONE);
        w.in_r0c2 = 32'h8000_0000; w.in_r2c0 = 32'h7FFF_FFFF;
        send_matrix(w);
        w = diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        w.in_r0c1 = 32'h7FFF_FFFF; w.in_r1c0 = 32'h8000_0000;
        send_matrix(w);
        // small diagonals: the determinant rounds to zero, yet the matrix is not singular
        send_matrix(diag(32'h0000_0100, 32'h0000_0080, 32'h0000_0001));
        send_matrix(diag(32'hFFFF_FF00, 32'h0000_0080, 32'h0000_0001));
        for (int k = 0; k < 5; k++) send_matrix(rand_matrix());

        // pause until every expected result is back
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 300) calm = 1'b1;
            send_matrix(rand_matrix());
        end
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        $display("sent %0d matrices, checked %0d results, %0d of them singular",
                 n_sent, n_results, n_singular);
        $display("covered extreme entries, ties, singular and near-singular matrices");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
sv/m3i_pkg.sv
sv/m3i_div.sv
sv/matrix3_inverse_top.sv
sim/matrix3_inverse_checker.sv
sim/matrix3_inverse_top_tb.sv
